/* rtl/c3x3_pkg.sv */
`timescale 1ns / 1ps

package c3x3_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

    localparam int KSEL_W   = 3;
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 13;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 13'd768;

    // Input item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [KSEL_W-1:0] {
        KERNEL_BOX      = 3'd0,
        KERNEL_SOBEL_R  = 3'd1,
        KERNEL_SOBEL_C  = 3'd2,
        KERNEL_SHARPEN  = 3'd3,
        KERNEL_EMBOSS   = 3'd4,
        KERNEL_GAUSSIAN = 3'd5
    } kernel_t;

    localparam int COEF_W = 5;
    localparam int SUM_W  = 13;

    localparam logic signed [COEF_W-1:0] KERNEL_COEF [6][9] = '{
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1},
        '{-5'sd1,  5'sd0,  5'sd1, -5'sd2,  5'sd0,  5'sd2, -5'sd1,  5'sd0,  5'sd1},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{-5'sd1, -5'sd1,  5'sd0, -5'sd1,  5'sd0,  5'sd1,  5'sd0,  5'sd1,  5'sd1},
        '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1}
    };

    // Reciprocal of nine in 16 fractional bits; exact for sums up to 9 * 255.
    localparam int          BOX_SUM_W   = 12;
    localparam int          BOX_PROD_W  = 25;
    localparam int          BOX_SHIFT   = 16;
    localparam logic [12:0] BOX_RECIP   = 13'd7282;
    localparam int          GAUSS_SHIFT = 4;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // Border flags of one window centre.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } pos_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             end_of_row;
        logic             last_of_frame;
    } out_item_t;

    function automatic logic signed [COEF_W-1:0] kernel_coef(input kernel_t k,
                                                            input logic [3:0] idx);
        return KERNEL_COEF[k][idx];
    endfunction

endpackage

/* rtl/conv3x3_kernel_select_filter.sv */
`timescale 1ns / 1ps

// 3x3 convolution over a raster stream of 8-bit grey pixels.
// Input channel: in_valid/in_stall with op and pixel_in. A transaction with op set
// is a drain beat and counts as a zero pixel. Send the W*H frame pixels followed by
// W+1 drain beats; the next transaction then starts a new frame.
// Output channel: out_valid/out_stall with pixel_out, end_of_row and last_of_frame.
// The result for centre pixel (r,c) belongs to the input transaction one row plus
// one pixel later and reaches the output through stages 1 to 3 and the queue.
// The first W+1 transactions of a frame produce no result.
// Throughput is one transaction per cycle unless in_stall is high: each transaction
// does one read and one write on each of the two line memories, pipelined over three
// stages. Results collect in an eight-entry queue; in_stall rises when the queue plus
// the results still in the pipeline would fill it, so a stalled receiver holds off
// the sender without losing anything.
// Configuration (kernel, width, height) is written through cfg_write/cfg_index/
// cfg_data and is picked up on the first transaction of each frame.
// Reset clears configuration to box kernel, 1024 x 768, empties the pipeline and
// queue and puts the position at the start of a frame. The line memories are not
// cleared: every entry read into an unmasked window tap is written earlier in the
// same frame.
module conv3x3_kernel_select_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [c3x3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [c3x3_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [7:0]                          pixel_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          pixel_out,
    output logic                                end_of_row,
    output logic                                last_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int SUM_W = c3x3_pkg::SUM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [c3x3_pkg::KSEL_W-1:0]  kernel_select_reg;
    logic [c3x3_pkg::IMG_W_W-1:0] image_width_reg;
    logic [c3x3_pkg::IMG_H_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_select_reg <= '0;
            image_width_reg   <= c3x3_pkg::IMAGE_WIDTH_RESET;
            image_height_reg  <= c3x3_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                c3x3_pkg::REG_KERNEL_SELECT:
                    kernel_select_reg <= cfg_data[c3x3_pkg::KSEL_W-1:0];
                c3x3_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[c3x3_pkg::IMG_W_W-1:0];
                c3x3_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[c3x3_pkg::IMG_H_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: frame position, border flags and line memory read
    // ------------------------------------------------------------------
    logic [AW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [WW-1:0]         fw_reg;
    logic [HW-1:0]         fh_reg;
    c3x3_pkg::kernel_t     fk_reg;

    logic [WW-1:0]         eff_w, cur_w, col_inc;
    logic [HW-1:0]         eff_h, cur_h;
    c3x3_pkg::kernel_t     eff_k, cur_k;
    logic                  frame_start;
    logic                  in_accept;
    logic                  acc_res;
    c3x3_pkg::pos_t        acc_pos;
    logic [7:0]            acc_x;

    // Pipeline registers
    logic                  s1_valid_reg, s1_res_reg, s1_hit_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [7:0]            s1_x_reg;
    c3x3_pkg::pos_t        s1_pos_reg;
    c3x3_pkg::kernel_t     s1_k_reg;

    logic                  s2_res_reg;
    c3x3_pkg::pos_t        s2_pos_reg;
    c3x3_pkg::kernel_t     s2_k_reg;

    logic                  s3_res_reg;
    c3x3_pkg::pos_t        s3_pos_reg;
    c3x3_pkg::kernel_t     s3_k_reg;
    logic signed [SUM_W-1:0] s3_sum_reg;

    // Result queue
    c3x3_pkg::out_item_t   fifo_mem [c3x3_pkg::FIFO_DEPTH];
    logic [c3x3_pkg::FIFO_AW-1:0] fifo_wr_reg, fifo_rd_reg;
    logic [c3x3_pkg::FIFO_CW-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic [c3x3_pkg::FIFO_CW-1:0] occupancy;
    logic                  fifo_rd;

    always_comb
    begin
        if (image_width_reg == '0)
            eff_w = WW'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(image_width_reg);

        if (image_height_reg == '0)
            eff_h = HW'(1);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(image_height_reg);

        if (kernel_select_reg > c3x3_pkg::KERNEL_GAUSSIAN)
            eff_k = c3x3_pkg::KERNEL_GAUSSIAN;
        else
            eff_k = c3x3_pkg::kernel_t'(kernel_select_reg);
    end

    assign frame_start = (row_reg == '0) && (col_reg == '0);
    assign cur_w       = frame_start ? eff_w : fw_reg;
    assign cur_h       = frame_start ? eff_h : fh_reg;
    assign cur_k       = frame_start ? eff_k : fk_reg;
    assign col_inc     = WW'(col_reg) + WW'(1);
    assign acc_x       = (op == c3x3_pkg::OP_DRAIN) ? 8'd0 : pixel_in;

    // The window centre sits one pixel back in the previous row; at column zero it
    // is the last pixel of the row before that.
    always_comb
    begin
        if (col_reg != '0)
        begin
            acc_res        = row_reg >= RW'(1);
            acc_pos.top    = row_reg == RW'(1);
            acc_pos.bottom = row_reg == RW'(cur_h);
            acc_pos.left   = col_reg == AW'(1);
            acc_pos.right  = 1'b0;
        end
        else
        begin
            acc_res        = row_reg >= RW'(2);
            acc_pos.top    = row_reg == RW'(2);
            acc_pos.bottom = row_reg == RW'(cur_h) + RW'(1);
            acc_pos.left   = cur_w == WW'(1);
            acc_pos.right  = 1'b1;
        end
        acc_pos.last = acc_pos.bottom && acc_pos.right;
    end

    always_comb
    begin
        if (acc_res && acc_pos.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= cur_w)
        begin
            col_next = '0;
            row_next = row_reg + RW'(1);
        end
        else
        begin
            col_next = AW'(col_inc);
            row_next = row_reg;
        end
    end

    assign occupancy = fifo_cnt_reg + c3x3_pkg::FIFO_CW'(s1_res_reg)
                     + c3x3_pkg::FIFO_CW'(s2_res_reg) + c3x3_pkg::FIFO_CW'(s3_res_reg);
    assign in_stall  = occupancy >= c3x3_pkg::FIFO_CW'(c3x3_pkg::FIFO_DEPTH);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            fw_reg  <= WW'(1);
            fh_reg  <= HW'(1);
            fk_reg  <= c3x3_pkg::KERNEL_BOX;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            fw_reg  <= cur_w;
            fh_reg  <= cur_h;
            fk_reg  <= cur_k;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line memory read-modify-write and window shift
    // ------------------------------------------------------------------
    logic [7:0] upper_mem  [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] upper_rd_reg, middle_rd_reg;
    logic [7:0] fwd_upper_reg, fwd_middle_reg;
    logic [7:0] upper_eff, middle_eff;
    logic [7:0] window_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s1_res_reg   <= in_accept && acc_res;
        end
    end

    // A transaction that follows the previous one to the same column (narrow
    // images) reads before that write lands, so it takes the written values
    // from the bypass registers instead.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= col_reg;
            s1_x_reg    <= acc_x;
            s1_pos_reg  <= acc_pos;
            s1_k_reg    <= cur_k;
            s1_hit_reg  <= s1_valid_reg && (s1_addr_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        upper_rd_reg  <= upper_mem[col_reg];
        middle_rd_reg <= middle_mem[col_reg];
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= middle_eff;
            middle_mem[s1_addr_reg] <= s1_x_reg;
        end
    end

    assign upper_eff  = s1_hit_reg ? fwd_upper_reg  : upper_rd_reg;
    assign middle_eff = s1_hit_reg ? fwd_middle_reg : middle_rd_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fwd_upper_reg  <= middle_eff;
            fwd_middle_reg <= s1_x_reg;
            for (int k = 0; k < 3; k++)
            begin
                window_reg[k * 3 + 0] <= window_reg[k * 3 + 1];
                window_reg[k * 3 + 1] <= window_reg[k * 3 + 2];
            end
            window_reg[2] <= upper_eff;
            window_reg[5] <= middle_eff;
            window_reg[8] <= s1_x_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted sum over the window, border taps masked
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_res_reg <= 1'b0;
        else
            s2_res_reg <= s1_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_pos_reg <= s1_pos_reg;
        s2_k_reg   <= s1_k_reg;
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!((k == 0 && s2_pos_reg.top) || (k == 2 && s2_pos_reg.bottom) ||
                      (j == 0 && s2_pos_reg.left) || (j == 2 && s2_pos_reg.right)))
                begin
                    sum = sum + SUM_W'($signed({1'b0, window_reg[k * 3 + j]}))
                              * SUM_W'(c3x3_pkg::kernel_coef(s2_k_reg, 4'(k * 3 + j)));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: normalize box and Gaussian sums by their kernel sums and clamp
    // ------------------------------------------------------------------
    logic [c3x3_pkg::BOX_PROD_W-1:0] box_prod;
    logic signed [SUM_W-1:0]         quot;
    logic [7:0]                      clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_res_reg <= 1'b0;
        else
            s3_res_reg <= s2_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_pos_reg <= s2_pos_reg;
        s3_k_reg   <= s2_k_reg;
        s3_sum_reg <= sum;
    end

    // Box and Gaussian sums are never negative, so truncation toward zero is a
    // plain floor there.
    assign box_prod = c3x3_pkg::BOX_PROD_W'(s3_sum_reg[c3x3_pkg::BOX_SUM_W-1:0])
                    * c3x3_pkg::BOX_PROD_W'(c3x3_pkg::BOX_RECIP);

    always_comb
    begin
        case (s3_k_reg)
            c3x3_pkg::KERNEL_BOX:
                quot = $signed(SUM_W'(box_prod[c3x3_pkg::BOX_PROD_W-1:c3x3_pkg::BOX_SHIFT]));
            c3x3_pkg::KERNEL_GAUSSIAN:
                quot = s3_sum_reg >>> c3x3_pkg::GAUSS_SHIFT;
            default:
                quot = s3_sum_reg;
        endcase

        if (quot < 0)
            clamped = 8'd0;
        else if (quot > $signed(SUM_W'(c3x3_pkg::PIX_MAX)))
            clamped = c3x3_pkg::PIX_MAX;
        else
            clamped = quot[7:0];
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign out_valid = fifo_cnt_reg != '0;
    assign fifo_rd   = out_valid && !out_stall;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (s3_res_reg && !fifo_rd)
            fifo_cnt_next = fifo_cnt_reg + c3x3_pkg::FIFO_CW'(1);
        else if (!s3_res_reg && fifo_rd)
            fifo_cnt_next = fifo_cnt_reg - c3x3_pkg::FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (s3_res_reg)
                fifo_wr_reg <= fifo_wr_reg + c3x3_pkg::FIFO_AW'(1);
            if (fifo_rd)
                fifo_rd_reg <= fifo_rd_reg + c3x3_pkg::FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_res_reg)
        begin
            fifo_mem[fifo_wr_reg].pixel         <= clamped;
            fifo_mem[fifo_wr_reg].end_of_row    <= s3_pos_reg.right;
            fifo_mem[fifo_wr_reg].last_of_frame <= s3_pos_reg.last;
        end
    end

    assign pixel_out     = fifo_mem[fifo_rd_reg].pixel;
    assign end_of_row    = fifo_mem[fifo_rd_reg].end_of_row;
    assign last_of_frame = fifo_mem[fifo_rd_reg].last_of_frame;

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= c3x3_pkg::FIFO_CW'(c3x3_pkg::FIFO_DEPTH))
        else $error("result queue count exceeds its depth");

    // The input throttle must leave room for every result that reaches the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_res_reg |-> (fifo_cnt_reg < c3x3_pkg::FIFO_CW'(c3x3_pkg::FIFO_DEPTH)) || fifo_rd)
        else $error("result written into a full queue");

    // The bypass is only selected when the previous transaction wrote last cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit_reg) |-> $past(s1_valid_reg))
        else $error("line memory bypass taken without a preceding write");

    // The final result of a frame returns the position to the frame start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && acc_res && acc_pos.last) |=> (col_reg == '0 && row_reg == '0))
        else $error("frame position not cleared after the last result");
`endif

endmodule
